[design/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and helpers of the four-level page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_XLATE = 2'd1;
  localparam logic [1:0] CMD_UNMAP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_WINDOW = 2'd2;

  // page size codes
  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  // walk levels, top first
  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_DIR  = 2'd1;
  localparam logic [1:0] LVL_MID  = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  localparam logic [63:0] ADDR_FIELD  = 64'h000F_FFFF_FFFF_F000;
  localparam logic [47:0] OFS_1G      = 48'h0000_3FFF_FFFF;
  localparam logic [47:0] OFS_2M      = 48'h0000_001F_FFFF;
  localparam logic [47:0] OFS_4K      = 48'h0000_0000_0FFF;
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_HUGE    = 7;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] word_address;
    logic [63:0] write_data;
    logic [47:0] virtual_address;
  } ptw_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [52:0] physical_address;
    logic [63:0] entry_flags;
    logic [1:0]  page_size;
  } ptw_res_t;

  // 9-bit table index of the virtual address at a level
  function automatic logic [8:0] va_slice(input logic [47:0] va, input logic [1:0] lvl);
    logic [8:0] s;
    case (lvl)
      LVL_TOP: s = va[47:39];
      LVL_DIR: s = va[38:30];
      LVL_MID: s = va[29:21];
      default: s = va[20:12];
    endcase
    return s;
  endfunction

endpackage

[design/ptw_table_mem.sv]
// ----------------------------------------------------------------------------
// ptw_table_mem
// Single-port table memory of 64-bit words with registered read data.
// ----------------------------------------------------------------------------
module ptw_table_mem #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [$clog2(MEM_WORDS)-1:0] addr_i,
  input  logic [63:0]                  wdata_i,
  output logic [63:0]                  rdata_o
);

  logic [63:0] mem_q [MEM_WORDS];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/ptw_index_unit.sv]
// ----------------------------------------------------------------------------
// ptw_index_unit
// Shared word-index unit: forms a table word index from a table base and
// a 9-bit slot, and checks it against the memory window.
// ----------------------------------------------------------------------------
module ptw_index_unit #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic [39:0]                  base_i,
  input  logic [8:0]                   slot_i,
  output logic                         in_window_o,
  output logic [$clog2(MEM_WORDS)-1:0] addr_o
);

  localparam logic [48:0] MemWordsW = 49'(MEM_WORDS);

  logic [48:0] word_idx;

  // a 4K table holds 512 words, so the slot fills the low bits
  assign word_idx    = {base_i, slot_i};
  assign in_window_o = word_idx < MemWordsW;
  assign addr_o      = word_idx[$clog2(MEM_WORDS)-1:0];

endmodule

[design/four_level_page_table_walker_unit.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit: write, translate and unmap on a local table memory
// From accept the sequencer enters issue, where a write or skip finishes; a walk then reads
// each level through the single memory port and evaluates it; the result strobe is registered.
// A new word is taken in the cycle the result strobe is shown; results cannot stall.
// Reset clears the sequencer, result strobe and root base; table memory is not cleared.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit
  import ptw_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ptw_cmd_t    cmd_i,
  output logic        done_o,
  output ptw_res_t    res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = $clog2(MEM_WORDS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  level_q, level_d;
  logic        done_q;
  ptw_cmd_t    cmd_q;
  ptw_res_t    res_q, fin_res;
  logic        fin;
  logic [51:0] root_q;

  logic             accept;
  logic             mem_we, mem_re;
  logic [63:0]      mem_wdata, rdata;
  logic [AddrW-1:0] mem_addr;
  logic [39:0]      unit_base;
  logic [8:0]       unit_slot;
  logic             in_window;
  logic             present, huge;
  logic             descend, clear_leaf, map_hit;
  logic [1:0]       map_size;
  logic [47:0]      ofs_mask;

  assign accept = start && !busy;
  assign busy   = state_q != S_IDLE;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : {12'd0, root_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      root_q <= pwdata[51:0];
    end
  end

  // ---------------------------------------------------------- shared units
  ptw_table_mem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(rdata)
  );

  ptw_index_unit #(
    .MEM_WORDS(MEM_WORDS)
  ) u_index (
    .base_i     (unit_base),
    .slot_i     (unit_slot),
    .in_window_o(in_window),
    .addr_o     (mem_addr)
  );

  always_comb begin
    if (state_q == S_EVAL) begin
      unit_base = rdata[51:12];
      unit_slot = va_slice(cmd_q.virtual_address, 2'(level_q + 2'd1));
    end else if (cmd_q.command == CMD_WRITE) begin
      unit_base = 40'(cmd_q.word_address[11:9]);
      unit_slot = cmd_q.word_address[8:0];
    end else begin
      unit_base = root_q[51:12];
      unit_slot = va_slice(cmd_q.virtual_address, LVL_TOP);
    end
  end

  // ------------------------------------------------------------- sequencer
  assign present = rdata[BIT_PRESENT];
  assign huge    = rdata[BIT_HUGE];

  always_comb begin
    descend    = 1'b0;
    clear_leaf = 1'b0;
    map_hit    = 1'b0;
    map_size   = PS_4K;
    if (cmd_q.command == CMD_XLATE) begin
      case (level_q)
        LVL_TOP: descend = present && !huge;
        LVL_DIR: begin
          descend  = present && !huge;
          map_hit  = present && huge;
          map_size = PS_1G;
        end
        LVL_MID: begin
          descend  = present && !huge;
          map_hit  = present && huge;
          map_size = PS_2M;
        end
        default: begin
          map_hit  = present;
          map_size = PS_4K;
        end
      endcase
    end else begin
      case (level_q)
        LVL_TOP: descend    = present;
        LVL_DIR: descend    = present && !huge;
        default: clear_leaf = present && !huge;
      endcase
    end
  end

  always_comb begin
    case (map_size)
      PS_1G:   ofs_mask = OFS_1G;
      PS_2M:   ofs_mask = OFS_2M;
      default: ofs_mask = OFS_4K;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    level_d   = level_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = cmd_q.write_data;
    fin       = 1'b0;
    fin_res   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (cmd_q.command)
          CMD_WRITE: begin
            fin            = 1'b1;
            mem_we         = in_window;
            fin_res.status = in_window ? ST_OK : ST_WINDOW;
          end
          CMD_XLATE, CMD_UNMAP: begin
            if (root_q[51:12] == 40'd0) begin
              fin            = 1'b1;
              fin_res.status = ST_MISS;
            end else if (!in_window) begin
              fin            = 1'b1;
              fin_res.status = ST_WINDOW;
            end else begin
              mem_re  = 1'b1;
              level_d = LVL_TOP;
              state_d = S_EVAL;
            end
          end
          default: begin
            fin            = 1'b1;
            fin_res.status = ST_MISS;
          end
        endcase
      end
      S_EVAL: begin
        if (descend || clear_leaf) begin
          if (!in_window) begin
            fin            = 1'b1;
            fin_res.status = ST_WINDOW;
          end else if (clear_leaf) begin
            fin            = 1'b1;
            mem_we         = 1'b1;
            mem_wdata      = 64'd0;
            fin_res.status = ST_OK;
          end else begin
            mem_re  = 1'b1;
            level_d = 2'(level_q + 2'd1);
          end
        end else if (map_hit) begin
          fin                      = 1'b1;
          fin_res.status           = ST_OK;
          fin_res.physical_address = 53'(rdata & ADDR_FIELD)
                                   + 53'(cmd_q.virtual_address & ofs_mask);
          fin_res.entry_flags      = rdata & ~ADDR_FIELD;
          fin_res.page_size        = map_size;
        end else begin
          fin            = 1'b1;
          fin_res.status = ST_MISS;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      level_q <= LVL_TOP;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      done_q  <= fin;
    end
  end

  // hold the command word and the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (fin) begin
      res_q <= fin_res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_ISSUE)
    else $error("accepted word did not enter issue");

  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> $past(mem_re))
    else $error("entry evaluated without a read");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != ST_OK |->
      res_o.physical_address == 53'd0 && res_o.entry_flags == 64'd0 &&
      res_o.page_size == PS_4K)
    else $error("failed result carries a translation");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write in one cycle");
`endif

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: four-level page-table walker
// Fills the whole table memory, then runs a directed walk over one known path
// and random write, translate and unmap words under several root bases and
// sender idle rates. A shadow table and walker predict every result.
// ----------------------------------------------------------------------------
module testbench;
  import ptw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS   = 4096;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam logic [3:0]  REG_ROOT    = 4'h0;
  localparam logic [1:0]  CMD_NONE    = 2'd3;

  // directed path: top table 1, then tables 2, 3 and 4
  localparam logic [47:0] PATH_VA = {9'h1FF, 9'h000, 9'h155, 9'h0AA, 12'hFFF};
  localparam logic [11:0] TOP_W   = 12'd1023;
  localparam logic [11:0] DIR_W   = 12'd1024;
  localparam logic [11:0] MID_W   = 12'd1877;
  localparam logic [11:0] LEAF_W  = 12'd2218;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  ptw_cmd_t    cmd_i;
  logic        done_o;
  ptw_res_t    res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ptw_cmd_t    cmd_backlog[$];
  ptw_res_t    res_due[$];
  logic [63:0] shadow_tbl [MEM_WORDS];
  logic [51:0] shadow_root = '0;
  int unsigned idle_pct    = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  logic        word_taken  = 1'b0;

  four_level_page_table_walker_unit #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly entries that point back into the eight tables of the window.
  function automatic logic [63:0] table_entry();
    logic [63:0] e;
    int unsigned r;
    e = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 80) begin
      e = (e & ~ADDR_FIELD) | (64'($urandom_range(0, 7)) << 12);
    end else if (r < 85) begin
      e = (e & ~ADDR_FIELD) | (64'($urandom_range(8, 15)) << 12);
    end
    e[BIT_PRESENT] = ($urandom_range(0, 99) < 90);
    e[BIT_HUGE]    = ($urandom_range(0, 99) < 15);
    return e;
  endfunction

  function automatic ptw_cmd_t table_write(input logic [11:0] addr, input logic [63:0] data);
    ptw_cmd_t c;
    c.command         = CMD_WRITE;
    c.word_address    = addr;
    c.write_data      = data;
    c.virtual_address = 48'({$urandom, $urandom});
    return c;
  endfunction

  function automatic ptw_cmd_t walk_word(input logic [1:0] op, input logic [47:0] va);
    ptw_cmd_t c;
    c.command         = op;
    c.word_address    = 12'($urandom);
    c.write_data      = {$urandom, $urandom};
    c.virtual_address = va;
    return c;
  endfunction

  function automatic ptw_cmd_t random_word();
    int unsigned r;
    logic [63:0] data;
    logic [47:0] va;
    r    = $urandom_range(0, 99);
    data = ($urandom_range(0, 99) < 80) ? table_entry() : {$urandom, $urandom};
    va   = 48'({$urandom, $urandom});
    if (r < 25) return table_write(12'($urandom), data);
    if (r < 75) return walk_word(CMD_XLATE, va);
    if (r < 93) return walk_word(CMD_UNMAP, va);
    return walk_word(CMD_NONE, va);
  endfunction

  // Walk the shadow tables the way the block does and build its result word.
  task automatic predict_walk(input ptw_cmd_t c, output ptw_res_t r);
    logic [63:0] ptr;
    logic [63:0] ent;
    logic [63:0] w;
    logic [63:0] pa;
    logic [47:0] ofs;
    logic [8:0]  idx;
    int          lvl;
    int          hit_lvl;
    bit          stop;
    bit          hit;
    r        = '0;
    r.status = ST_MISS;
    hit      = 1'b0;
    hit_lvl  = 0;
    ent      = '0;
    case (c.command)
      CMD_WRITE: begin
        if (c.word_address < MEM_WORDS) begin
          shadow_tbl[c.word_address] = c.write_data;
          r.status = ST_OK;
        end else begin
          r.status = ST_WINDOW;
        end
      end
      CMD_XLATE, CMD_UNMAP: begin
        ptr  = {12'b0, shadow_root};
        stop = ((ptr & ADDR_FIELD) == '0);
        for (lvl = 0; lvl < 4 && !stop; lvl++) begin
          idx = 9'(c.virtual_address >> (39 - 9 * lvl));
          w   = ((ptr & ADDR_FIELD) >> 3) + 64'(idx);
          if (w >= MEM_WORDS) begin
            r.status = ST_WINDOW;
            stop     = 1'b1;
          end else if (c.command == CMD_UNMAP && lvl == 3) begin
            // leaf is cleared whether or not it was present
            shadow_tbl[w[11:0]] = '0;
            r.status = ST_OK;
            stop     = 1'b1;
          end else begin
            ent = shadow_tbl[w[11:0]];
            if (!ent[BIT_PRESENT]) begin
              stop = 1'b1;
            end else if (ent[BIT_HUGE] && lvl != 3 && !(c.command == CMD_UNMAP && lvl == 0)) begin
              // huge at top faults; lower huge maps on translate, skips on unmap
              stop    = 1'b1;
              hit     = (c.command == CMD_XLATE && lvl != 0);
              hit_lvl = lvl;
            end else if (lvl == 3) begin
              stop    = 1'b1;
              hit     = 1'b1;
              hit_lvl = lvl;
            end else begin
              ptr = ent;
            end
          end
        end
        if (hit) begin
          ofs = (hit_lvl == 1) ? OFS_1G : (hit_lvl == 2) ? OFS_2M : OFS_4K;
          pa  = (ent & ADDR_FIELD) + {16'b0, c.virtual_address & ofs};
          r.status           = ST_OK;
          r.physical_address = pa[52:0];
          r.entry_flags      = ent & ~ADDR_FIELD;
          r.page_size        = (hit_lvl == 1) ? PS_1G : (hit_lvl == 2) ? PS_2M : PS_4K;
        end
      end
      default: r.status = ST_MISS;
    endcase
  endtask

  // Write the root base, then read it back in the following transfer.
  task automatic set_root_base(input logic [63:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_ROOT;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[51:0] !== value[51:0]) begin
      $display("%0t: root_table_base readback expected %h actual %h",
               $time, value[51:0], prdata[51:0]);
      fail_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || start || res_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [63:0] root, input int unsigned idle,
                           input int count, input int chunk);
    set_root_base(root);
    idle_pct = idle;
    for (int i = 0; i < count; i++) begin
      cmd_backlog.push_back(random_word());
      // hold off until the block has answered everything
      if (chunk != 0 && (i % chunk) == chunk - 1) wait_drained();
    end
    wait_drained();
  endtask

  // Driver: hold a word until it is taken, then offer the next one.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || word_taken)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        cmd_i <= cmd_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: retire results, then predict the word taken at this edge.
  always @(posedge clk_i) begin
    ptw_res_t due;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_ROOT) begin
        shadow_root = pwdata[51:0];
      end
      if (done_o) begin
        if (res_due.size() == 0) begin
          $display("%0t: result with none due: status %0d pa %h flags %h size %0d", $time,
                   res_o.status, res_o.physical_address, res_o.entry_flags, res_o.page_size);
          fail_count++;
        end else begin
          due = res_due.pop_front();
          if (res_o.status !== due.status) begin
            $display("%0t: status expected %0d actual %0d", $time, due.status, res_o.status);
            fail_count++;
          end
          if (res_o.physical_address !== due.physical_address) begin
            $display("%0t: physical_address expected %h actual %h", $time,
                     due.physical_address, res_o.physical_address);
            fail_count++;
          end
          if (res_o.entry_flags !== due.entry_flags) begin
            $display("%0t: entry_flags expected %h actual %h", $time,
                     due.entry_flags, res_o.entry_flags);
            fail_count++;
          end
          if (res_o.page_size !== due.page_size) begin
            $display("%0t: page_size expected %0d actual %0d", $time,
                     due.page_size, res_o.page_size);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        predict_walk(cmd_i, due);
        res_due.push_back(due);
      end
      word_taken <= start && !busy;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("four_level_page_table_walker_unit: mismatch");
      $finish;
    end
  end

  initial begin
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // load every table word so that no walk reads an unwritten one
    set_root_base(64'h0000_0000_0000_1000);
    idle_pct = 0;
    for (int w = 0; w < MEM_WORDS; w++) begin
      cmd_backlog.push_back(table_write(12'(w),
        ($urandom_range(0, 99) < 90) ? table_entry() : {$urandom, $urandom}));
    end
    wait_drained();

    // known path through tables 1 to 4, with all-ones leaf fields
    cmd_backlog.push_back(table_write(TOP_W, 64'h2001));
    cmd_backlog.push_back(table_write(DIR_W, 64'h3001));
    cmd_backlog.push_back(table_write(MID_W, 64'h4001));
    cmd_backlog.push_back(table_write(LEAF_W, ALL_ONES));
    cmd_backlog.push_back(walk_word(CMD_XLATE, PATH_VA));
    cmd_backlog.push_back(walk_word(CMD_XLATE, {PATH_VA[47:12], 12'h000}));
    // huge middle entry: 2M page, sum carries into bit 52
    cmd_backlog.push_back(table_write(MID_W, ALL_ONES));
    cmd_backlog.push_back(walk_word(CMD_XLATE, PATH_VA));
    // huge directory entry: 1G page
    cmd_backlog.push_back(table_write(DIR_W, ALL_ONES));
    cmd_backlog.push_back(walk_word(CMD_XLATE, PATH_VA));
    // huge top entry faults a walk; unmap follows it out of the window
    cmd_backlog.push_back(table_write(TOP_W, ALL_ONES));
    cmd_backlog.push_back(walk_word(CMD_XLATE, PATH_VA));
    cmd_backlog.push_back(walk_word(CMD_UNMAP, PATH_VA));
    // absent top entry
    cmd_backlog.push_back(table_write(TOP_W, 64'h0));
    cmd_backlog.push_back(walk_word(CMD_XLATE, PATH_VA));
    cmd_backlog.push_back(walk_word(CMD_UNMAP, PATH_VA));
    // restore the path, unmap the leaf, then miss on it
    cmd_backlog.push_back(table_write(TOP_W, 64'h2001));
    cmd_backlog.push_back(table_write(DIR_W, 64'h3001));
    cmd_backlog.push_back(table_write(MID_W, 64'h4001));
    cmd_backlog.push_back(walk_word(CMD_UNMAP, PATH_VA));
    cmd_backlog.push_back(walk_word(CMD_XLATE, PATH_VA));
    // leaf table just past the window
    cmd_backlog.push_back(table_write(MID_W, 64'h8001));
    cmd_backlog.push_back(walk_word(CMD_XLATE, PATH_VA));
    cmd_backlog.push_back(walk_word(CMD_UNMAP, PATH_VA));
    cmd_backlog.push_back(walk_word(CMD_NONE, PATH_VA));
    cmd_backlog.push_back(table_write(12'hFFF, 64'h0));
    cmd_backlog.push_back(table_write(12'h000, ALL_ONES));
    wait_drained();

    run_phase(64'h0000_0000_0000_1000, 0, 150, 0);
    run_phase(64'h0000_0000_0000_7FFF, 50, 150, 0);
    run_phase(64'h0000_0000_0000_0000, 9, 30, 0);
    run_phase(ALL_ONES, 50, 30, 0);
    run_phase(64'h0000_0000_0000_3ABC, 9, 150, 25);

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("four_level_page_table_walker_unit: match");
    end else begin
      $display("four_level_page_table_walker_unit: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
design/ptw_pkg.sv
design/ptw_table_mem.sv
design/ptw_index_unit.sv
design/four_level_page_table_walker_unit.sv
dv/testbench.sv
